// ===== design/stia_pkg.sv =====
// ----------------------------------------------------------------------------
// stia_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package stia_pkg;

  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_SIGN,
    BK_EMIT
  } back_state_e;

endpackage

// ===== design/stia_front.sv =====
// ----------------------------------------------------------------------------
// stia_front
// Accepts input words, splits them into sign and unsigned magnitude and
// pushes them into the work queue.
// ----------------------------------------------------------------------------
module stia_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output logic [VALUE_WIDTH:0]   q_data_o
);

  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;

  // most negative value wraps to 2^(w-1), correct as an unsigned magnitude
  assign neg      = value_i[VALUE_WIDTH-1];
  assign mag      = neg ? (~value_i + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : value_i;
  assign busy     = q_full_i;
  assign q_push_o = start && !q_full_i;
  assign q_data_o = {neg, mag};

endmodule

// ===== design/stia_queue.sv =====
// ----------------------------------------------------------------------------
// stia_queue
// Two-entry queue between the front and the back end.
// ----------------------------------------------------------------------------
module stia_queue #(
  parameter int unsigned WIDTH = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/stia_back.sv =====
// ----------------------------------------------------------------------------
// stia_back
// Converts a magnitude to packed bcd by shift-and-add-3, one bit per cycle,
// then emits an optional minus sign and the digits, most significant first.
// ----------------------------------------------------------------------------
module stia_back
  import stia_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  logic [VALUE_WIDTH:0]   q_data_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  output logic [CHAR_W-1:0]      char_code_o,
  output logic                   last_o
);

  localparam int unsigned NDIG      = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_W     = NDIG * DIGIT_W;
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int unsigned DIG_CNT_W = $clog2(NDIG);
  localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_WIDTH - 1);
  localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(NDIG - 1);

  back_state_e            state_q, state_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_adj;
  logic                   neg_q, neg_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]   dig_cnt_q, dig_cnt_d;
  logic                   started_q, started_d;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   dig_last;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign top_digit = bcd_q[BCD_W-1 -: DIGIT_W];
  assign dig_last  = (dig_cnt_q == DIG_LAST);

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    neg_d       = neg_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    started_d   = started_q;
    q_pop_o     = 1'b0;
    out_valid_o = 1'b0;
    char_code_o = CHAR_ZERO + {2'b00, top_digit};
    last_o      = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o        = 1'b1;
          {neg_d, mag_d} = q_data_i;
          bcd_d          = '0;
          bit_cnt_d      = '0;
          state_d        = BK_CONV;
        end
      end
      BK_CONV: begin
        bcd_d     = {bcd_adj[BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
        mag_d     = {mag_q[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q + 1'b1;
        dig_cnt_d = '0;
        started_d = 1'b0;
        if (bit_cnt_q == BIT_LAST) begin
          state_d = neg_q ? BK_SIGN : BK_EMIT;
        end
      end
      BK_SIGN: begin
        out_valid_o = 1'b1;
        char_code_o = CHAR_MINUS;
        state_d     = BK_EMIT;
      end
      BK_EMIT: begin
        // leading zeros are dropped, the units digit always goes out
        out_valid_o = started_q || (top_digit != 4'd0) || dig_last;
        last_o      = dig_last;
        started_d   = started_q || (top_digit != 4'd0);
        bcd_d       = {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        dig_cnt_d   = dig_cnt_q + 1'b1;
        if (dig_last) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q     <= mag_d;
    bcd_q     <= bcd_d;
    neg_q     <= neg_d;
    bit_cnt_q <= bit_cnt_d;
    dig_cnt_q <= dig_cnt_d;
    started_q <= started_d;
  end

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts signed integers to decimal ascii text, one character per word.
//
//   channel  direction  handshake                ports
//   input    in         start & !busy            value_i
//   result   out        out_valid_o (1 cycle)    char_code_o, last_o
//
// Each word passes through the back end states in order: shift-and-add-3
// conversion, the minus sign if negative, and NDIG digit positions (10 at
// 32 bits), then idle before the next word is popped from the queue.
// The two-entry queue lets the front take up to two more words meanwhile;
// busy is high while it is full. Reset clears the queue and the back end.
// Results cannot be stalled; each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
  import stia_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] value_i,
  output logic                   out_valid_o,
  output logic [CHAR_W-1:0]      char_code_o,
  output logic                   last_o
);

  logic                 q_push;
  logic [VALUE_WIDTH:0] q_push_data;
  logic                 q_full;
  logic                 q_pop;
  logic [VALUE_WIDTH:0] q_pop_data;
  logic                 q_empty;

  stia_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .start    (start),
    .busy     (busy),
    .value_i  (value_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_push_data)
  );

  stia_queue #(
    .WIDTH(VALUE_WIDTH + 1)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  stia_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_pop_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  // a minus sign never ends a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (char_code_o == CHAR_MINUS) |-> !last_o)
    else $error("minus sign flagged as last");

  // only the sign or a digit is ever emitted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o == CHAR_MINUS) ||
                    ((char_code_o >= CHAR_ZERO) && (char_code_o <= 6'd57)))
    else $error("bad character code");

  // the back end passes through idle after each run, so no word follows directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |=> !out_valid_o)
    else $error("word directly after last character");

endmodule
